@@ hw/rtl/swms_pkg.sv @@
// Package for the mid/side stereo widener.
// Holds types, constants, the sine table generator and rounding helpers.
// No dependencies.
package swms_pkg;

    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int VAL_W = 32;
    localparam int ACC_W = 58;
    localparam int MA_W  = 34;
    localparam int MB_W  = 23;
    localparam int CFG_W = 17;

    localparam logic signed [VAL_W-1:0] ONE_Q20          = 32'sd1048576;
    localparam logic signed [MB_W-1:0]  PI_Q20           = 23'sd3294199;
    localparam logic signed [MB_W-1:0]  FOUR_OVER_PI_Q20 = 23'sd1335089;
    localparam logic signed [MB_W-1:0]  THIRD_Q20        = 23'sd349525;
    localparam logic [15:0]             DENSITY_ONE      = 16'd16384;
    localparam logic [CFG_W-1:0]        GAIN_ONE         = 17'd65536;

    localparam longint HALF_PI_Q30     = 64'sd1686629713;
    localparam longint CORDIC_GAIN_Q30 = 64'sd652032875;

    localparam logic [1:0] CFG_DENSITY       = 2'd0;
    localparam logic [1:0] CFG_SUSTAIN       = 2'd1;
    localparam logic [1:0] CFG_HIGHPASS_GAIN = 2'd2;
    localparam logic [1:0] CFG_CENTER_SQUISH = 2'd3;

    localparam longint ATAN_Q30 [30] = '{
        843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388438, 4194283, 2097150, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2
    };

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SIN_ARG, OP_SIN_MUL, OP_SIN_OUT, OP_PASS,
        OP_FRAC_A, OP_FRAC_B, OP_FRAC_R,
        OP_SUS_A, OP_SUS_T, OP_SUS_B, OP_SUS_C, OP_SUS_R,
        OP_HP_A, OP_HP_OFF, OP_HP_B, OP_HP_K, OP_HP_C, OP_HP_D, OP_HP_R,
        OP_MID_A, OP_MID_T, OP_MID_B, OP_MID_C, OP_MID_R, OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        ARG_SIDE, ARG_COMP, ARG_MID
    } arg_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_SIN_ARG, S_SIN_MUL, S_SIN_OUT, S_PASS,
        S_FRAC_A, S_FRAC_B, S_FRAC_R,
        S_SUS_A, S_SUS_T, S_SUS_B, S_SUS_C, S_SUS_R,
        S_HP_A, S_HP_OFF, S_HP_B, S_HP_K, S_HP_C, S_HP_D, S_HP_R,
        S_MID_A, S_MID_T, S_MID_B, S_MID_C, S_MID_R, S_OUT
    } state_t;

    typedef struct packed {
        op_t  op;
        arg_t arg;
    } cmd_t;

    typedef struct packed {
        logic cnt_gt_one;
    } status_t;

    function automatic logic [31:0] sine_entry(int idx, int tb);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = CORDIC_GAIN_Q30;
        y = 0;
        z = (longint'(idx) * HALF_PI_Q30) >>> tb;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_Q30[i];
            end
            else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_Q30[i];
            end
        end
        if (y < 0) y = 0;
        if (y > (64'sd1 <<< 30)) y = 64'sd1 <<< 30;
        return y[31:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] round_acc(
        logic signed [ACC_W-1:0] v, int sh);
        logic signed [ACC_W-1:0] r;
        r = (v + (ACC_W'(1) <<< (sh - 1))) >>> sh;
        return r[VAL_W-1:0];
    endfunction

endpackage

@@ hw/rtl/swms_ctrl.sv @@
// Controller for the mid/side stereo widener.
// Sequences datapath operations for one frame; owns the handshakes.
// Depends on swms_pkg.
module swms_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  swms_pkg::status_t status,
    output swms_pkg::cmd_t    cmd
);
    import swms_pkg::*;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_CHECK;
            S_CHECK:
            begin
                state_next = S_SIN_ARG;
                ret_next   = status.cnt_gt_one ? S_PASS : S_FRAC_A;
            end
            S_SIN_ARG: state_next = S_SIN_MUL;
            S_SIN_MUL: state_next = S_SIN_OUT;
            S_SIN_OUT: state_next = ret_reg;
            S_PASS:    state_next = S_CHECK;
            S_FRAC_A:  state_next = S_FRAC_B;
            S_FRAC_B:  state_next = S_FRAC_R;
            S_FRAC_R:
            begin
                state_next = S_SIN_ARG;
                ret_next   = S_SUS_A;
            end
            S_SUS_A:   state_next = S_SUS_T;
            S_SUS_T:   state_next = S_SUS_B;
            S_SUS_B:   state_next = S_SUS_C;
            S_SUS_C:   state_next = S_SUS_R;
            S_SUS_R:   state_next = S_HP_A;
            S_HP_A:    state_next = S_HP_OFF;
            S_HP_OFF:  state_next = S_HP_B;
            S_HP_B:    state_next = S_HP_K;
            S_HP_K:    state_next = S_HP_C;
            S_HP_C:    state_next = S_HP_D;
            S_HP_D:    state_next = S_HP_R;
            S_HP_R:
            begin
                state_next = S_SIN_ARG;
                ret_next   = S_MID_A;
            end
            S_MID_A:   state_next = S_MID_T;
            S_MID_T:   state_next = S_MID_B;
            S_MID_B:   state_next = S_MID_C;
            S_MID_C:   state_next = S_MID_R;
            S_MID_R:   state_next = S_OUT;
            S_OUT:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op  = OP_NONE;
        cmd.arg = ARG_SIDE;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:    cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_CHECK:   cmd.op = OP_NONE;
            S_SIN_ARG:
            begin
                cmd.op = OP_SIN_ARG;
                if (ret_reg == S_SUS_A) cmd.arg = ARG_COMP;
                else if (ret_reg == S_MID_A) cmd.arg = ARG_MID;
                else cmd.arg = ARG_SIDE;
            end
            S_SIN_MUL: cmd.op = OP_SIN_MUL;
            S_SIN_OUT: cmd.op = OP_SIN_OUT;
            S_PASS:    cmd.op = OP_PASS;
            S_FRAC_A:  cmd.op = OP_FRAC_A;
            S_FRAC_B:  cmd.op = OP_FRAC_B;
            S_FRAC_R:  cmd.op = OP_FRAC_R;
            S_SUS_A:   cmd.op = OP_SUS_A;
            S_SUS_T:   cmd.op = OP_SUS_T;
            S_SUS_B:   cmd.op = OP_SUS_B;
            S_SUS_C:   cmd.op = OP_SUS_C;
            S_SUS_R:   cmd.op = OP_SUS_R;
            S_HP_A:    cmd.op = OP_HP_A;
            S_HP_OFF:  cmd.op = OP_HP_OFF;
            S_HP_B:    cmd.op = OP_HP_B;
            S_HP_K:    cmd.op = OP_HP_K;
            S_HP_C:    cmd.op = OP_HP_C;
            S_HP_D:    cmd.op = OP_HP_D;
            S_HP_R:    cmd.op = OP_HP_R;
            S_MID_A:   cmd.op = OP_MID_A;
            S_MID_T:   cmd.op = OP_MID_T;
            S_MID_B:   cmd.op = OP_MID_B;
            S_MID_C:   cmd.op = OP_MID_C;
            S_MID_R:   cmd.op = OP_MID_R;
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.op = OP_OUT;
                    out_valid_next = 1'b1;
                end
            end
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

@@ hw/rtl/swms_dp.sv @@
// Datapath for the mid/side stereo widener.
// Config registers, sine table, shared multiply-accumulate, output registers.
// Depends on swms_pkg.
module swms_dp #(
    parameter int SAMPLE_BITS     = swms_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = swms_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [swms_pkg::CFG_W-1:0]    cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    input  swms_pkg::cmd_t                cmd,
    output swms_pkg::status_t             status
);
    import swms_pkg::*;

    localparam int TBL_N  = 1 << SINE_TABLE_BITS;
    localparam int IDX_W  = SINE_TABLE_BITS + 1;
    localparam int SH     = 20 - SINE_TABLE_BITS;
    localparam int SP_W   = 33 + SH + 1;
    localparam int IN_SH  = (SAMPLE_BITS > 21) ? SAMPLE_BITS - 21 : 0;
    localparam int IN_LSH = (SAMPLE_BITS < 21) ? 21 - SAMPLE_BITS : 0;
    localparam int CV_W   = 48;
    localparam logic signed [CV_W-1:0] IN_RND  = (CV_W'(1) <<< IN_SH) >>> 1;
    localparam logic signed [CV_W-1:0] OUT_RND = (CV_W'(1) <<< IN_LSH) >>> 1;
    localparam logic signed [CV_W-1:0] OUT_MAX = (CV_W'(1) <<< (SAMPLE_BITS - 1)) - CV_W'(1);
    localparam logic signed [CV_W-1:0] OUT_MIN = -OUT_MAX - CV_W'(1);

    logic [15:0]      density_reg, sustain_reg;
    logic [CFG_W-1:0] hpg_reg, csq_reg;

    logic signed [VAL_W-1:0] mid_reg, mid_next;
    logic signed [VAL_W-1:0] side_reg, side_next;
    logic signed [VAL_W-1:0] s_reg, s_next;
    logic signed [VAL_W-1:0] tmp_reg, tmp_next;
    logic signed [VAL_W-1:0] hp_reg, hp_next;
    logic [15:0]             cnt_reg, cnt_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [20:0]             u_reg, u_next;
    logic signed [VAL_W-1:0] base_reg, base_next;
    logic signed [SP_W-1:0]  sprod_reg, sprod_next;
    logic signed [SAMPLE_BITS-1:0] left_reg, left_next, right_reg, right_next;

    logic [31:0] sine_rom [0:TBL_N];

    for (genvar gi = 0; gi <= TBL_N; gi++)
    begin : g_rom
        localparam logic [31:0] ENT = sine_entry(gi, SINE_TABLE_BITS);
        assign sine_rom[gi] = ENT;
    end

    logic [CFG_W-1:0]        g_eff, cs_eff;
    logic signed [MA_W-1:0]  side_x, mid_x, side_abs, mid_abs, arg;
    logic signed [MA_W-1:0]  s_sgn, t_sgn, tm_sgn;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic                    mul_clr, mul_add;
    logic signed [ACC_W-1:0] prod;
    logic [IDX_W-1:0]        idx, idx_hi;
    logic signed [32:0]      diff;
    logic signed [33:0]      sin_v;
    logic signed [CV_W-1:0]  l_ext, r_ext, l_cv, r_cv;
    logic signed [VAL_W-1:0] rnd20, rnd16, rnd14;
    logic signed [CV_W-1:0]  lh, rh, lo_cv, ro_cv;

    assign g_eff  = hpg_reg[CFG_W-1] ? GAIN_ONE : hpg_reg;
    assign cs_eff = csq_reg[CFG_W-1] ? GAIN_ONE : csq_reg;
    assign status.cnt_gt_one = (cnt_reg > DENSITY_ONE);
    assign left_out  = left_reg;
    assign right_out = right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            density_reg <= '0;
            sustain_reg <= '0;
            hpg_reg     <= '0;
            csq_reg     <= '0;
            hp_reg      <= '0;
        end
        else
        begin
            hp_reg <= hp_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DENSITY:       density_reg <= cfg_data[15:0];
                    CFG_SUSTAIN:       sustain_reg <= cfg_data[15:0];
                    CFG_HIGHPASS_GAIN: hpg_reg     <= cfg_data;
                    CFG_CENTER_SQUISH: csq_reg     <= cfg_data;
                    default:           density_reg <= density_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg   <= mid_next;
        side_reg  <= side_next;
        s_reg     <= s_next;
        tmp_reg   <= tmp_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        u_reg     <= u_next;
        base_reg  <= base_next;
        sprod_reg <= sprod_next;
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    always_comb
    begin
        side_x   = MA_W'(side_reg);
        mid_x    = MA_W'(mid_reg);
        side_abs = (side_x < 0) ? -side_x : side_x;
        mid_abs  = (mid_x < 0) ? -mid_x : mid_x;
        s_sgn    = (side_reg > 0) ? MA_W'(s_reg) : -MA_W'(s_reg);
        t_sgn    = (side_reg > 0) ? MA_W'(tmp_reg) : -MA_W'(tmp_reg);
        tm_sgn   = (mid_reg > 0) ? MA_W'(tmp_reg) : -MA_W'(tmp_reg);
        case (cmd.arg)
            ARG_COMP: arg = MA_W'(ONE_Q20) - side_abs;
            ARG_MID:  arg = mid_abs >>> 1;
            default:  arg = side_abs;
        endcase

        mul_a   = '0;
        mul_b   = '0;
        mul_clr = 1'b0;
        mul_add = 1'b0;
        case (cmd.op)
            OP_FRAC_A:
            begin
                mul_a = side_x;
                mul_b = MB_W'($signed({1'b0, DENSITY_ONE})) - MB_W'($signed({1'b0, cnt_reg}));
                mul_clr = 1'b1;
            end
            OP_FRAC_B:
            begin
                mul_a = s_sgn;
                mul_b = MB_W'($signed({1'b0, cnt_reg}));
                mul_add = 1'b1;
            end
            OP_SUS_A:
            begin
                mul_a = MA_W'(ONE_Q20) - MA_W'(s_reg);
                mul_b = PI_Q20;
                mul_clr = 1'b1;
            end
            OP_SUS_B:
            begin
                mul_a = side_x;
                mul_b = MB_W'($signed({1'b0, GAIN_ONE})) - MB_W'($signed({1'b0, sustain_reg}));
                mul_clr = 1'b1;
            end
            OP_SUS_C:
            begin
                mul_a = t_sgn;
                mul_b = MB_W'($signed({1'b0, sustain_reg}));
                mul_add = 1'b1;
            end
            OP_HP_A:
            begin
                mul_a = MA_W'(ONE_Q20) + side_abs;
                mul_b = THIRD_Q20;
                mul_clr = 1'b1;
            end
            OP_HP_B:
            begin
                mul_a = MA_W'(tmp_reg);
                mul_b = MB_W'($signed({1'b0, g_eff}));
                mul_clr = 1'b1;
            end
            OP_HP_C:
            begin
                mul_a = MA_W'(hp_reg);
                mul_b = MB_W'(ONE_Q20 - tmp_reg);
                mul_clr = 1'b1;
            end
            OP_HP_D:
            begin
                mul_a = side_x;
                mul_b = MB_W'(tmp_reg);
                mul_add = 1'b1;
            end
            OP_MID_A:
            begin
                mul_a = MA_W'(s_reg);
                mul_b = FOUR_OVER_PI_Q20;
                mul_clr = 1'b1;
            end
            OP_MID_B:
            begin
                mul_a = mid_x;
                mul_b = MB_W'($signed({1'b0, GAIN_ONE})) - MB_W'($signed({1'b0, cs_eff}));
                mul_clr = 1'b1;
            end
            OP_MID_C:
            begin
                mul_a = tm_sgn;
                mul_b = MB_W'($signed({1'b0, cs_eff}));
                mul_add = 1'b1;
            end
            default:
            begin
                mul_clr = 1'b0;
            end
        endcase
        prod = ACC_W'(mul_a) * ACC_W'(mul_b);
    end

    always_comb
    begin
        idx    = u_reg[20:SH];
        idx_hi = (idx == IDX_W'(TBL_N)) ? idx : idx + IDX_W'(1);
        diff   = $signed({1'b0, sine_rom[idx_hi]}) - $signed({1'b0, sine_rom[idx]});
        sin_v  = 34'(base_reg) + 34'(sprod_reg >>> SH);
        rnd20  = round_acc(acc_reg, 20);
        rnd16  = round_acc(acc_reg, 16);
        rnd14  = round_acc(acc_reg, 14);

        l_ext = CV_W'(left_in);
        r_ext = CV_W'(right_in);
        l_cv  = ((l_ext <<< IN_LSH) + IN_RND) >>> IN_SH;
        r_cv  = ((r_ext <<< IN_LSH) + IN_RND) >>> IN_SH;

        lh = (CV_W'(mid_reg) + CV_W'(side_reg)) >>> 1;
        rh = (CV_W'(mid_reg) - CV_W'(side_reg)) >>> 1;
        lo_cv = ((lh + OUT_RND) >>> IN_LSH) <<< IN_SH;
        ro_cv = ((rh + OUT_RND) >>> IN_LSH) <<< IN_SH;
        if (lo_cv > OUT_MAX) lo_cv = OUT_MAX;
        if (lo_cv < OUT_MIN) lo_cv = OUT_MIN;
        if (ro_cv > OUT_MAX) ro_cv = OUT_MAX;
        if (ro_cv < OUT_MIN) ro_cv = OUT_MIN;
    end

    always_comb
    begin
        mid_next   = mid_reg;
        side_next  = side_reg;
        s_next     = s_reg;
        tmp_next   = tmp_reg;
        hp_next    = hp_reg;
        cnt_next   = cnt_reg;
        u_next     = u_reg;
        base_next  = base_reg;
        sprod_next = sprod_reg;
        left_next  = left_reg;
        right_next = right_reg;
        acc_next   = acc_reg;
        if (mul_clr) acc_next = prod;
        else if (mul_add) acc_next = acc_reg + prod;
        case (cmd.op)
            OP_LOAD:
            begin
                mid_next  = VAL_W'(l_cv + r_cv);
                side_next = VAL_W'(l_cv - r_cv);
                cnt_next  = density_reg;
            end
            OP_SIN_ARG:
            begin
                if (arg < 0) u_next = '0;
                else if (arg > MA_W'(ONE_Q20)) u_next = 21'(ONE_Q20);
                else u_next = arg[20:0];
            end
            OP_SIN_MUL:
            begin
                base_next  = $signed(sine_rom[idx]);
                sprod_next = SP_W'(diff) * SP_W'($signed({1'b0, u_reg[SH-1:0]}));
            end
            OP_SIN_OUT: s_next = VAL_W'((sin_v + 34'sd512) >>> 10);
            OP_PASS:
            begin
                side_next = VAL_W'(s_sgn);
                cnt_next  = cnt_reg - DENSITY_ONE;
            end
            OP_FRAC_R: side_next = rnd14;
            OP_SUS_T:  tmp_next  = rnd20;
            OP_SUS_R:  side_next = rnd16;
            OP_HP_OFF: tmp_next  = (rnd20 > ONE_Q20) ? ONE_Q20 : rnd20;
            OP_HP_K:   tmp_next  = rnd16;
            OP_HP_R:
            begin
                hp_next   = rnd20;
                side_next = side_reg - rnd20;
            end
            OP_MID_T:  tmp_next  = rnd20;
            OP_MID_R:  mid_next  = rnd16;
            OP_OUT:
            begin
                left_next  = lo_cv[SAMPLE_BITS-1:0];
                right_next = ro_cv[SAMPLE_BITS-1:0];
            end
            default:   cnt_next = cnt_reg;
        endcase
    end

endmodule

@@ hw/rtl/stereo_widener_mid_side_top.sv @@
// Top level of the mid/side stereo widener.
// Joins the controller (swms_ctrl) and the datapath (swms_dp); uses swms_pkg.
//
// Usage:
//   Input beats (left_in, right_in) are taken on in_valid with in_stall low;
//   result beats (left_out, right_out) are offered on out_valid and held
//   while out_stall is high. One result beat per input beat, in order.
//   Configuration is written through cfg_we, cfg_index and cfg_data while
//   the block is idle; index 0 density, 1 sustain, 2 highpass_gain,
//   3 center_squish.
// Operation:
//   A frame first makes P whole sine-shaping passes, where P is zero for
//   density up to 16384, else density/16384 rounded up, minus one. The
//   frame walks a shared multiply-accumulate and a table sine unit
//   (argument, multiply and output steps) under a state machine, one frame
//   at a time. A new beat is taken as soon as the previous result sits in
//   the output register.
// Reset:
//   rst_n clears the config registers, highpass memory and all handshakes.
//   A stalled result holds; the frame after it waits at its final step.
module stereo_widener_mid_side_top #(
    parameter int SAMPLE_BITS     = swms_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = swms_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [swms_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);
    import swms_pkg::*;

    cmd_t    cmd;
    status_t status;

    swms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    swms_dp #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .left_in   (left_in),
        .right_in  (right_in),
        .left_out  (left_out),
        .right_out (right_out),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
